/* hw/rtl/dmxlf_pkg.sv */
// ----------------------------------------------------------------------------
// dmxlf_pkg
// shared types and codes of the dmx512 link framer
// ----------------------------------------------------------------------------
package dmxlf_pkg;

   localparam int SLOT_W  = 10;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;
   localparam int FUNC_W  = 3;
   localparam int MODE_W  = 2;

   // request function codes
   localparam logic [FUNC_W-1:0] FN_RX_BYTE  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_RX_BREAK = 3'd1;
   localparam logic [FUNC_W-1:0] FN_TX_DONE  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_READ     = 3'd3;
   localparam logic [FUNC_W-1:0] FN_WRITE    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_POLL     = 3'd5;

   // link modes, code 3 behaves as off
   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RX  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TX  = 2'd2;

   localparam logic [BYTE_W-1:0] START_DMX = 8'h00;
   localparam logic [BYTE_W-1:0] START_RDM = 8'hCC;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BREAK,
      ST_DMX_RECV,
      ST_DMX_COMPLETE,
      ST_RDM_RECV,
      ST_DMX_TX
   } link_state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_TX_READ,
      OP_HOST_READ
   } op_kind_type;

   // work handed from the front to the back
   typedef struct packed {
      op_kind_type         kind;
      logic                bank;
      logic [SLOT_W-1:0]   addr;
      logic [BYTE_W-1:0]   wdata;
      logic                tx_valid;
      logic                tx_is_break;
      logic                new_frame;
      logic [COUNT_W-1:0]  frame_count;
      logic                rdm_ready;
      logic [SLOT_W-1:0]   rdm_length;
   } op_type;

   typedef struct packed {
      logic                tx_valid;
      logic [BYTE_W-1:0]   tx_byte;
      logic                tx_is_break;
      logic [BYTE_W-1:0]   read_data;
      logic                new_frame;
      logic [COUNT_W-1:0]  frame_count;
      logic                rdm_ready;
      logic [SLOT_W-1:0]   rdm_length;
   } rsp_type;

endpackage

/* hw/rtl/dmx512_link_framer.sv */
// ----------------------------------------------------------------------------
// dmx512_link_framer
// dmx512 / rdm slot framer with double-banked slot memory
// ----------------------------------------------------------------------------
// throughput: one request and one result per cycle unless a queue fills or the
//   banks are being cleared, set by one bank access per cycle in the back end
// reset: synchronous; afterwards both banks are zeroed by a pass over all
//   SLOTS+1 addresses during which full stays high (csr writes are still taken)
// ----------------------------------------------------------------------------
module dmx512_link_framer #(
   parameter int SLOTS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dmxlf_pkg::MODE_W-1:0]       csr_link_mode,
   // request side
   input  logic                               push,
   output logic                               full,
   input  logic [dmxlf_pkg::FUNC_W-1:0]       req_func,
   input  logic [dmxlf_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic [dmxlf_pkg::SLOT_W-1:0]       req_slot_address,
   input  logic [dmxlf_pkg::BYTE_W-1:0]       req_slot_value,
   // result side
   output logic                               empty,
   input  logic                               pop,
   output logic                               rsp_tx_valid,
   output logic [dmxlf_pkg::BYTE_W-1:0]       rsp_tx_byte,
   output logic                               rsp_tx_is_break,
   output logic [dmxlf_pkg::BYTE_W-1:0]       rsp_read_data,
   output logic                               rsp_new_frame,
   output logic [dmxlf_pkg::COUNT_W-1:0]      rsp_frame_count,
   output logic                               rsp_rdm_ready,
   output logic [dmxlf_pkg::SLOT_W-1:0]       rsp_rdm_length
);
   import dmxlf_pkg::*;

   localparam int MQD = 4;

   logic                 csr_fire;
   logic                 accept;
   logic                 op_push;
   op_type               op;
   op_type               mid_op;
   logic                 mid_empty;
   logic                 mid_full;
   logic                 mid_pop;
   logic [$clog2(MQD):0] mid_count;
   logic                 clearing;
   rsp_type              rsp;

   // the register must only be written while the link is quiet (the user's duty, not enforced here), so always ready
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // hold off requests while the banks are being zeroed
   assign full   = mid_full || clearing;
   assign accept = push && !full;

   // front: link state machine and slot counter, turns each request into
   // at most one bank access plus the result fields known up front
   dmxlf_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_fire      (csr_fire),
      .csr_link_mode (csr_link_mode),
      .accept        (accept),
      .func          (req_func),
      .rx_byte       (req_rx_byte),
      .slot_address  (req_slot_address),
      .slot_value    (req_slot_value),
      .op_push       (op_push),
      .op            (op)
   );

   // decoupling queue, lets the back stall without stopping the front
   dmxlf_fifo #(
      .item_type (op_type),
      .DEPTH     (MQD)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_item (op),
      .pop       (mid_pop),
      .head_item (mid_op),
      .empty     (mid_empty),
      .full      (mid_full),
      .count     (mid_count)
   );

   // back: bank reads and writes, result assembly and result queue
   dmxlf_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_op    (mid_op),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .clearing  (clearing),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp       (rsp)
   );

   assign rsp_tx_valid    = rsp.tx_valid;
   assign rsp_tx_byte     = rsp.tx_byte;
   assign rsp_tx_is_break = rsp.tx_is_break;
   assign rsp_read_data   = rsp.read_data;
   assign rsp_new_frame   = rsp.new_frame;
   assign rsp_frame_count = rsp.frame_count;
   assign rsp_rdm_ready   = rsp.rdm_ready;
   assign rsp_rdm_length  = rsp.rdm_length;

   // the mid queue never holds more than its depth
   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      mid_count <= ($clog2(MQD)+1)'(MQD))
      else $error("request queue count out of range");

endmodule

/* hw/rtl/dmxlf_fifo.sv */
// ----------------------------------------------------------------------------
// dmxlf_fifo
// small register queue, depth a power of two
// ----------------------------------------------------------------------------
module dmxlf_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  item_type                   push_item,
   input  logic                       pop,
   output item_type                   head_item,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH):0]     count
);
   localparam int PW = $clog2(DEPTH);

   item_type           entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != (PW+1)'(DEPTH)))
      else $error("queue written while full");

endmodule

/* hw/rtl/dmxlf_front.sv */
// ----------------------------------------------------------------------------
// dmxlf_front
// link state, slot counter and frame bookkeeping, one request a cycle while requests are accepted
// ----------------------------------------------------------------------------
module dmxlf_front #(
   parameter int SLOTS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_fire,
   input  logic [dmxlf_pkg::MODE_W-1:0]       csr_link_mode,
   input  logic                               accept,
   input  logic [dmxlf_pkg::FUNC_W-1:0]       func,
   input  logic [dmxlf_pkg::BYTE_W-1:0]       rx_byte,
   input  logic [dmxlf_pkg::SLOT_W-1:0]       slot_address,
   input  logic [dmxlf_pkg::BYTE_W-1:0]       slot_value,
   output logic                               op_push,
   output dmxlf_pkg::op_type                  op
);
   import dmxlf_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS);
   localparam logic [SLOT_W-1:0] TX_END    = SLOT_W'(SLOTS + 1);
   localparam logic [SLOT_W:0]   ADDR_MAX  = (SLOT_W+1)'(SLOTS);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   link_state_type     state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               live_ff, live_in;
   logic [COUNT_W-1:0] frames_ff, frames_in;
   logic               flag_ff, flag_in;

   logic [SLOT_W-1:0]  slot_inc;
   logic               slot_room;
   logic               addr_ok;
   logic               is_rx;
   logic               is_tx;

   assign slot_inc  = slot_ff + 1'b1;
   assign slot_room = (slot_ff < LAST_SLOT);
   assign addr_ok   = ({1'b0, slot_address} <= ADDR_MAX);
   assign is_rx     = (mode_ff == MODE_RX);
   assign is_tx     = (mode_ff == MODE_TX);

   // next state
   always_comb begin
      mode_in   = mode_ff;
      state_in  = state_ff;
      slot_in   = slot_ff;
      live_in   = live_ff;
      frames_in = frames_ff;
      flag_in   = flag_ff;
      if (csr_fire) begin
         mode_in  = csr_link_mode;
         slot_in  = '0;
         state_in = (csr_link_mode == MODE_TX) ? ST_BREAK : ST_IDLE;
      end else if (accept) begin
         case (func)
            FN_RX_BYTE: begin
               if (is_rx) begin
                  case (state_ff)
                     ST_BREAK: begin
                        if (rx_byte == START_DMX) begin
                           state_in = ST_DMX_RECV;
                        end else if (rx_byte == START_RDM) begin
                           state_in = ST_RDM_RECV;
                        end else begin
                           state_in = ST_IDLE;
                        end
                     end
                     ST_DMX_RECV, ST_RDM_RECV: begin
                        if (slot_room) begin
                           slot_in = slot_inc;
                        end
                        if (!slot_room || slot_inc >= LAST_SLOT) begin
                           state_in = (state_ff == ST_DMX_RECV) ? ST_DMX_COMPLETE : ST_IDLE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            FN_RX_BREAK: begin
               if (is_rx) begin
                  if (state_ff == ST_DMX_RECV || state_ff == ST_DMX_COMPLETE) begin
                     frames_in = frames_ff + 1'b1;
                     live_in   = ~live_ff;
                     flag_in   = 1'b1;
                  end
                  slot_in  = '0;
                  state_in = ST_BREAK;
               end
            end
            FN_TX_DONE: begin
               if (is_tx) begin
                  if (state_ff == ST_BREAK) begin
                     state_in = ST_DMX_TX;
                  end else if (state_ff == ST_DMX_TX) begin
                     if (slot_ff >= TX_END) begin
                        slot_in  = '0;
                        state_in = ST_BREAK;
                     end else begin
                        slot_in = slot_inc;
                     end
                  end
               end
            end
            FN_POLL: begin
               flag_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // work item for the back
   always_comb begin
      op             = '0;
      op.kind        = OP_NONE;
      op.bank        = live_ff;
      op.frame_count = frames_in;
      case (func)
         FN_RX_BYTE: begin
            if (is_rx && (state_ff == ST_DMX_RECV || state_ff == ST_RDM_RECV)
                && slot_room) begin
               op.kind  = OP_WRITE;
               op.addr  = slot_inc;
               op.wdata = rx_byte;
            end
         end
         FN_RX_BREAK: begin
            if (is_rx && state_ff == ST_RDM_RECV) begin
               op.rdm_ready  = 1'b1;
               op.rdm_length = slot_ff;
            end
         end
         FN_TX_DONE: begin
            if (is_tx && state_ff == ST_BREAK) begin
               op.tx_valid = 1'b1;
            end else if (is_tx && state_ff == ST_DMX_TX) begin
               op.tx_valid = 1'b1;
               if (slot_ff >= TX_END) begin
                  op.tx_is_break = 1'b1;
               end else begin
                  op.kind = OP_TX_READ;
                  op.addr = slot_ff;
               end
            end
         end
         FN_READ: begin
            if (addr_ok) begin
               op.kind = OP_HOST_READ;
               op.bank = ~live_ff;
               op.addr = slot_address;
            end
         end
         FN_WRITE: begin
            if (addr_ok) begin
               op.kind  = OP_WRITE;
               op.addr  = slot_address;
               op.wdata = slot_value;
            end
         end
         FN_POLL: begin
            op.new_frame = flag_ff;
         end
         default: ;
      endcase
   end

   assign op_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         state_ff  <= ST_IDLE;
         slot_ff   <= '0;
         live_ff   <= 1'b0;
         frames_ff <= '0;
         flag_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         live_ff   <= live_in;
         frames_ff <= frames_in;
         flag_ff   <= flag_in;
      end
   end

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= TX_END)
      else $error("slot counter past end of frame");

   a_tx_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DMX_TX) |-> (mode_ff == MODE_TX))
      else $error("transmit state outside transmit mode");

endmodule

/* hw/rtl/dmxlf_back.sv */
// ----------------------------------------------------------------------------
// dmxlf_back
// slot banks, clearing pass and result queue
// ----------------------------------------------------------------------------
module dmxlf_back #(
   parameter int SLOTS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dmxlf_pkg::op_type     mid_op,
   input  logic                  mid_empty,
   output logic                  mid_pop,
   output logic                  clearing,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output dmxlf_pkg::rsp_type    rsp
);
   import dmxlf_pkg::*;

   localparam int DEPTH = SLOTS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int QD    = 4;
   localparam int CW    = $clog2(QD) + 1;

   logic [BYTE_W-1:0] bank_a [DEPTH];
   logic [BYTE_W-1:0] bank_b [DEPTH];

   logic              clearing_ff, clearing_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              pipe_vld_ff;
   op_type            pipe_op_ff;
   logic [BYTE_W-1:0] a_rdata_ff, b_rdata_ff;

   logic              issue;
   logic              credit_ok;
   logic [CW-1:0]     out_count;
   logic              out_full;
   logic              a_we, b_we;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [BYTE_W-1:0] rdata;
   rsp_type           result;

   // keep room in the result queue for the access in flight
   assign credit_ok = ({1'b0, out_count} + (CW+1)'(pipe_vld_ff)) < (CW+1)'(QD);
   assign issue     = !clearing_ff && !mid_empty && credit_ok;
   assign mid_pop   = issue;
   assign clearing  = clearing_ff;

   assign mem_addr  = clearing_ff ? clr_ff : mid_op.addr[AW-1:0];
   assign mem_wdata = clearing_ff ? '0 : mid_op.wdata;
   assign a_we = clearing_ff || (issue && mid_op.kind == OP_WRITE && !mid_op.bank);
   assign b_we = clearing_ff || (issue && mid_op.kind == OP_WRITE &&  mid_op.bank);

   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         if (clr_ff == AW'(SLOTS)) begin
            clearing_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         pipe_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pipe_op_ff <= mid_op;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         bank_a[mem_addr] <= mem_wdata;
      end
      a_rdata_ff <= bank_a[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bank_b[mem_addr] <= mem_wdata;
      end
      b_rdata_ff <= bank_b[mem_addr];
   end

   assign rdata = pipe_op_ff.bank ? b_rdata_ff : a_rdata_ff;

   always_comb begin
      result.tx_valid    = pipe_op_ff.tx_valid;
      result.tx_byte     = (pipe_op_ff.kind == OP_TX_READ) ? rdata : '0;
      result.tx_is_break = pipe_op_ff.tx_is_break;
      result.read_data   = (pipe_op_ff.kind == OP_HOST_READ) ? rdata : '0;
      result.new_frame   = pipe_op_ff.new_frame;
      result.frame_count = pipe_op_ff.frame_count;
      result.rdm_ready   = pipe_op_ff.rdm_ready;
      result.rdm_length  = pipe_op_ff.rdm_length;
   end

   dmxlf_fifo #(
      .item_type (rsp_type),
      .DEPTH     (QD)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (pipe_vld_ff),
      .push_item (result),
      .pop       (rsp_pop && !rsp_empty),
      .head_item (rsp),
      .empty     (rsp_empty),
      .full      (out_full),
      .count     (out_count)
   );

   a_credit: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> !out_full)
      else $error("result arrived with no room in the result queue");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> ($past(clr_ff) == AW'(SLOTS)))
      else $error("clearing pass ended early");

endmodule
